/* rtl/t3l_pkg.sv */
// ----------------------------------------------------------------------------
// t3l_pkg
// Shared types and codes for the tetrahedral 3d lut color grader.
// ----------------------------------------------------------------------------
`default_nettype none

package t3l_pkg;

  // command codes of an input beat
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_LUT_EDGE    = 3'd0;
  localparam logic [2:0] CFG_DOMAIN_LOW  = 3'd1;
  localparam logic [2:0] CFG_DOMAIN_HIGH = 3'd2;
  localparam logic [2:0] CFG_INDEX_SCALE = 3'd3;
  localparam logic [2:0] CFG_STRENGTH    = 3'd4;
  localparam logic [2:0] CFG_LUT_ENABLED = 3'd5;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // unity in q.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic        command;
    logic [15:0] entry_index;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic [15:0] alpha_in;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
    logic        beyond_domain;
  } out_beat_t;

endpackage

`default_nettype wire

/* rtl/tetrahedral_3d_lut_grade_top.sv */
// ----------------------------------------------------------------------------
// tetrahedral_3d_lut_grade_top
// Color grade of rgba pixels through a 3d lut with tetrahedral interpolation.
// ----------------------------------------------------------------------------
// an accepted pixel beat passes stages 0 to 8 in order to become its result beat
// throughput: one beat per cycle while out_ready_i keeps the stages moving, set by the
//   nine register stages and the two dual-read copies of the cube memory that serve the four corners at once
// table-write beats leave at the memory stage and give no result
// reset clears control and configuration; the cube is undefined until written
`default_nettype none

module tetrahedral_3d_lut_grade_top #(
  parameter int MAX_EDGE     = 33,
  parameter int CHANNEL_BITS = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  t3l_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output t3l_pkg::out_beat_t                  out_data_o,
  input  wire                                 cfg_we_i,
  input  wire [t3l_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [t3l_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_EDGE);
  localparam int NW    = $clog2(MAX_EDGE + 1);
  localparam int NS    = 9;
  localparam logic [17:0] CHAN_MAX = 18'((64'd1 << CHANNEL_BITS) - 64'd1);

  // configuration registers
  logic [5:0]  edge_q;
  logic [15:0] low_q, high_q;
  logic [23:0] scale_q;
  logic [16:0] strength_q;
  logic        enabled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q     <= 6'd33;
      low_q      <= 16'd0;
      high_q     <= 16'hffff;
      scale_q    <= 24'd8192;
      strength_q <= 17'h10000;
      enabled_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        t3l_pkg::CFG_LUT_EDGE:    edge_q     <= cfg_data_i[5:0];
        t3l_pkg::CFG_DOMAIN_LOW:  low_q      <= cfg_data_i[15:0];
        t3l_pkg::CFG_DOMAIN_HIGH: high_q     <= cfg_data_i[15:0];
        t3l_pkg::CFG_INDEX_SCALE: scale_q    <= cfg_data_i[23:0];
        t3l_pkg::CFG_STRENGTH:    strength_q <= cfg_data_i[16:0];
        t3l_pkg::CFG_LUT_ENABLED: enabled_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped edge and blend strength
  logic [NW-1:0] n;
  logic [CW-1:0] nm1, nm2;
  logic [16:0]   s;
  logic [16:0]   s_inv;

  always_comb begin
    if (edge_q < 6'd2) begin
      n = NW'(2);
    end else if (32'(edge_q) > 32'(MAX_EDGE)) begin
      n = NW'(MAX_EDGE);
    end else begin
      n = NW'(edge_q);
    end
    nm1   = CW'(n - NW'(1));
    nm2   = CW'(n - NW'(2));
    s     = (strength_q > t3l_pkg::ONE_Q16) ? t3l_pkg::ONE_Q16 : strength_q;
    s_inv = t3l_pkg::ONE_Q16 - s;
  end

  // stage valids and ready chain
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = out_ready_i || !vld_q[NS-1];
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // beats carried along the stages
  logic        pix_q   [4];
  logic [15:0] idx_q   [4];
  logic [15:0] chan_q  [8][3];
  logic [15:0] alpha_q [8];
  logic        flag_q  [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          if (k == 4) vld_q[k] <= vld_q[k-1] && pix_q[3];
          else        vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      pix_q[0]     <= (in_data_i.command == t3l_pkg::CMD_PIXEL);
      idx_q[0]     <= in_data_i.entry_index;
      chan_q[0][0] <= in_data_i.red_in;
      chan_q[0][1] <= in_data_i.green_in;
      chan_q[0][2] <= in_data_i.blue_in;
      alpha_q[0]   <= in_data_i.alpha_in;
      flag_q[0]    <= (in_data_i.red_in > high_q) || (in_data_i.green_in > high_q) ||
                      (in_data_i.blue_in > high_q);
    end
    for (int k = 1; k < 8; k++) begin
      if (rdy[k]) begin
        chan_q[k]  <= chan_q[k-1];
        alpha_q[k] <= alpha_q[k-1];
        flag_q[k]  <= flag_q[k-1];
        if (k < 4) begin
          pix_q[k] <= pix_q[k-1];
          idx_q[k] <= idx_q[k-1];
        end
      end
    end
  end

  // stage 0: offset from domain low times index scale
  logic [39:0] prod_q [3];
  logic [15:0] in_v   [3];

  assign in_v[0] = in_data_i.red_in;
  assign in_v[1] = in_data_i.green_in;
  assign in_v[2] = in_data_i.blue_in;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= 40'((in_v[c] >= low_q) ? (in_v[c] - low_q) : 16'd0) * 40'(scale_q);
      end
    end
  end

  // stage 1: grid coordinate, clamp, cell index and fraction
  logic [CW+15:0] top;
  logic [CW+15:0] tc   [3];
  logic [CW-1:0]  ip   [3];
  logic [CW-1:0]  ci_d [3];
  logic [16:0]    fr_d [3];
  logic [CW-1:0]  ci_q [3];
  logic [16:0]    fr_q [3];

  always_comb begin
    top = {nm1, 16'd0};
    for (int c = 0; c < 3; c++) begin
      tc[c]   = (prod_q[c][39:8] > 32'(top)) ? top : prod_q[c][CW+23:8];
      ip[c]   = tc[c][CW+15:16];
      ci_d[c] = (ip[c] > nm2) ? nm2 : ip[c];
      fr_d[c] = 17'(tc[c] - {ci_d[c], 16'd0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ci_q <= ci_d;
      fr_q <= fr_d;
    end
  end

  // stage 2: tetrahedron choice, weights, corners, row part of address
  logic [1:0]    ax0, ax1, ax2;
  logic [CW-1:0] cp   [4][3];
  logic [16:0]   w_d  [4];
  logic [16:0]   w_q  [4];
  logic [AW-1:0] part_q [4];
  logic [CW-1:0] red_q  [4];

  always_comb begin
    if (fr_q[0] > fr_q[1]) begin
      if (fr_q[1] > fr_q[2])      begin ax0 = 2'd0; ax1 = 2'd1; ax2 = 2'd2; end
      else if (fr_q[0] > fr_q[2]) begin ax0 = 2'd0; ax1 = 2'd2; ax2 = 2'd1; end
      else                        begin ax0 = 2'd2; ax1 = 2'd0; ax2 = 2'd1; end
    end else begin
      if (fr_q[2] > fr_q[1])      begin ax0 = 2'd2; ax1 = 2'd1; ax2 = 2'd0; end
      else if (fr_q[2] > fr_q[0]) begin ax0 = 2'd1; ax1 = 2'd2; ax2 = 2'd0; end
      else                        begin ax0 = 2'd1; ax1 = 2'd0; ax2 = 2'd2; end
    end
    w_d[0] = t3l_pkg::ONE_Q16 - fr_q[ax0];
    w_d[1] = fr_q[ax0] - fr_q[ax1];
    w_d[2] = fr_q[ax1] - fr_q[ax2];
    w_d[3] = fr_q[ax2];
    for (int k = 0; k < 3; k++) begin
      cp[0][k] = ci_q[k];
      cp[1][k] = ci_q[k] + CW'(ax0 == 2'(k));
      cp[2][k] = cp[1][k] + CW'(ax1 == 2'(k));
      cp[3][k] = ci_q[k] + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      w_q <= w_d;
      for (int j = 0; j < 4; j++) begin
        part_q[j] <= AW'(AW'(cp[j][2]) * AW'(n) + AW'(cp[j][1]));
        red_q[j]  <= cp[j][0];
      end
    end
  end

  // stage 3: full corner addresses
  logic [AW-1:0] addr_q [4];
  logic [16:0]   w3_q   [4];

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      w3_q <= w_q;
      for (int j = 0; j < 4; j++) begin
        addr_q[j] <= AW'(part_q[j] * AW'(n) + AW'(red_q[j]));
      end
    end
  end

  // stage 4: cube memory, two copies with two read ports each
  logic [47:0]   mem_a [DEPTH];
  logic [47:0]   mem_b [DEPTH];
  logic [47:0]   ent_q [4];
  logic [16:0]   w4_q  [4];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [47:0]   mem_wd;

  assign mem_we = rdy[4] && vld_q[3] && !pix_q[3] && (32'(idx_q[3]) < 32'(DEPTH));
  assign mem_wa = AW'(idx_q[3]);
  assign mem_wd = {chan_q[3][2], chan_q[3][1], chan_q[3][0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_a[mem_wa] <= mem_wd;
      mem_b[mem_wa] <= mem_wd;
    end
    if (rdy[4]) begin
      ent_q[0] <= mem_a[addr_q[0]];
      ent_q[1] <= mem_a[addr_q[1]];
      ent_q[2] <= mem_b[addr_q[2]];
      ent_q[3] <= mem_b[addr_q[3]];
      w4_q     <= w3_q;
    end
  end

  // stage 5: corner weight times corner value
  logic [32:0] pr_q [3][4];

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 4; j++) begin
          pr_q[c][j] <= 33'(w4_q[j]) * 33'(ent_q[j][16*c +: 16]);
        end
      end
    end
  end

  // stage 6: graded value per channel
  logic [31:0] g_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int c = 0; c < 3; c++) begin
        g_q[c] <= 32'(35'(pr_q[c][0]) + 35'(pr_q[c][1]) + 35'(pr_q[c][2]) +
                      35'(pr_q[c][3]));
      end
    end
  end

  // stage 7: blend products
  logic [48:0] gs_q [3];
  logic [32:0] vs_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      for (int c = 0; c < 3; c++) begin
        gs_q[c] <= 49'(g_q[c]) * 49'(s);
        vs_q[c] <= 33'(chan_q[6][c]) * 33'(s_inv);
      end
    end
  end

  // stage 8: round, saturate and select pass-through
  logic [49:0] acc   [3];
  logic [17:0] rnd   [3];
  logic [15:0] res   [3];
  t3l_pkg::out_beat_t out_d, out_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = 50'(gs_q[c]) + {1'b0, vs_q[c], 16'd0} + 50'h0_0000_8000_0000;
      rnd[c] = acc[c][49:32];
      res[c] = (rnd[c] > CHAN_MAX) ? CHAN_MAX[15:0] : rnd[c][15:0];
    end
    out_d.red_out       = enabled_q ? res[0] : chan_q[7][0];
    out_d.green_out     = enabled_q ? res[1] : chan_q[7][1];
    out_d.blue_out      = enabled_q ? res[2] : chan_q[7][2];
    out_d.alpha_out     = alpha_q[7];
    out_d.beyond_domain = enabled_q && flag_q[7];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) out_q <= out_d;
  end

  assign out_data_o = out_q;

  // checks
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (vld_q == {NS{1'b1}}) || vld_q[0])
    else $error("input stalled with an empty first stage");

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (19'(w3_q[0]) + 19'(w3_q[1]) + 19'(w3_q[2]) + 19'(w3_q[3]) ==
                  19'(t3l_pkg::ONE_Q16)))
    else $error("corner weights do not sum to one");

  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] && !rdy[5] |=> vld_q[4] && $stable(ent_q[0]) && $stable(ent_q[3]))
    else $error("held memory read data changed");

  a_no_flag_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enabled_q |-> !out_data_o.beyond_domain)
    else $error("out of domain flag raised with the lut off");

  a_write_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !pix_q[3] && rdy[4] |=> !vld_q[4])
    else $error("table write beat produced a result");

endmodule

`default_nettype wire
